FILE: rtl/wtdr_pkg.sv
package wtdr_pkg;

	// Field widths of the words on the ports.
	localparam int RES_W      = 24;
	localparam int WEIGHT_W   = 24;
	localparam int NEURON_W   = 6;
	localparam int OUTPUT_W   = 3;
	localparam int OP_W       = 2;

	// Store geometry.
	localparam int NEURONS     = 64;
	localparam int OUTPUTS     = 8;
	localparam int STORE_DEPTH = NEURONS * OUTPUTS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Largest magnitude a weight can have.
	localparam logic [WEIGHT_W-1:0] MAG_MAX = WEIGHT_W'(1) << (WEIGHT_W - 1);

	// Serial arithmetic: one multiplier bit per cycle, one quotient bit per cycle.
	localparam int MUL_STEPS = RES_W;
	localparam int DIV_STEPS = 3 * RES_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int DH_W      = RES_W + 2;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = RES_W;
	localparam logic [RES_W-1:0] RON_RESET  = RES_W'(1000);
	localparam logic [RES_W-1:0] ROFF_RESET = RES_W'(100000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ON_RES,
		CFG_OFF_RES
	} cfg_reg_t;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]            operation;
		logic [NEURON_W-1:0]        neuron_index;
		logic [OUTPUT_W-1:0]        output_index;
		logic signed [WEIGHT_W-1:0] weight;
	} in_word_t;

	typedef struct packed {
		logic [RES_W-1:0]    positive_resistance;
		logic [RES_W-1:0]    negative_resistance;
		logic [WEIGHT_W-1:0] peak_weight;
		logic                status;
	} out_word_t;

	typedef struct packed {
		logic             start;
		logic [RES_W-1:0] ron;
		logic [RES_W-1:0] roff;
		logic [RES_W-1:0] amax;
		logic [RES_W-1:0] mag;
	} map_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] res;
	} map_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RDMEM,
		ST_CALC,
		ST_PUSH
	} top_state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_MUL1,
		M_MUL2,
		M_DIV,
		M_DONE
	} map_state_t;

endpackage

FILE: rtl/wtdr_ram.sv
module wtdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/wtdr_map.sv
module wtdr_map (
	input  logic                clk,
	input  logic                arst_n,
	input  wtdr_pkg::map_req_t  req,
	output wtdr_pkg::map_rsp_t  rsp
);

	localparam int RW = wtdr_pkg::RES_W;
	localparam int DW = wtdr_pkg::DH_W;
	localparam int CW = wtdr_pkg::CNT_W;

	wtdr_pkg::map_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// Operands captured at start; r_on and r_off - r_on are held, r_off, A and |w| are shifted.
	logic [RW-1:0]        ron_q;
	logic [RW-1:0]        r_q;
	logic signed [RW:0]   diff_q;
	logic [RW-1:0]        a_q;
	logic [RW-1:0]        m_q;

	// Denominator r_on*A + (r_off - r_on)*|w|, built LSB first.
	logic signed [DW-1:0] dh_q;
	logic [RW-1:0]        dl_q;
	// r_on*r_off.
	logic [RW-1:0]        ph_q;
	logic [RW-1:0]        pl_q;
	// Numerator r_on*r_off*A; it is shifted out MSB first during the divide.
	logic [2*RW-1:0]      nh_q;
	logic [RW-1:0]        nl_q;
	// Divider.
	logic [2*RW-1:0]      rem_q;
	logic [RW-1:0]        q_q;
	logic                 sat_q;

	logic                 step_last;
	logic signed [DW-1:0] den_add_a;
	logic signed [DW-1:0] den_add_m;
	logic signed [DW-1:0] den_sum;
	logic [RW:0]          p_sum;
	logic [2*RW:0]        n_sum;
	logic [DW+RW-1:0]     den_w;
	logic [2*RW-1:0]      den_mag;
	logic                 den_pos;
	logic [2*RW:0]        rem_shift;
	logic [2*RW:0]        rem_sub;
	logic                 q_bit;

	assign step_last = (cnt_q == '0);

	assign den_add_a = a_q[0] ? $signed({2'b00, ron_q}) : '0;
	assign den_add_m = m_q[0] ? $signed({diff_q[RW], diff_q}) : '0;
	assign den_sum   = dh_q + den_add_a + den_add_m;
	assign p_sum     = {1'b0, ph_q} + (r_q[0] ? {1'b0, ron_q} : '0);
	assign n_sum     = {1'b0, nh_q} + (a_q[0] ? {1'b0, ph_q, pl_q} : '0);

	assign den_w   = {dh_q, dl_q};
	assign den_mag = den_w[2*RW-1:0];
	assign den_pos = !dh_q[DW-1] && (|den_w);

	assign rem_shift = {rem_q, nh_q[2*RW-1]};
	assign rem_sub   = rem_shift - {1'b0, den_mag};
	assign q_bit     = (rem_shift >= {1'b0, den_mag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtdr_pkg::M_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rsp.done = 1'b0;
		rsp.res  = sat_q ? '1 : q_q;
		unique case (state_q)
			wtdr_pkg::M_IDLE: begin
				if (req.start) begin
					state_d = wtdr_pkg::M_MUL1;
					cnt_d   = CW'(wtdr_pkg::MUL_STEPS - 1);
				end
			end
			wtdr_pkg::M_MUL1: begin
				if (step_last) begin
					state_d = wtdr_pkg::M_MUL2;
					cnt_d   = CW'(wtdr_pkg::MUL_STEPS - 1);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			wtdr_pkg::M_MUL2: begin
				if (step_last) begin
					// A denominator at or below zero saturates without dividing.
					state_d = den_pos ? wtdr_pkg::M_DIV : wtdr_pkg::M_DONE;
					cnt_d   = CW'(wtdr_pkg::DIV_STEPS - 1);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			wtdr_pkg::M_DIV: begin
				if (step_last) begin
					state_d = wtdr_pkg::M_DONE;
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			wtdr_pkg::M_DONE: begin
				rsp.done = 1'b1;
				state_d  = wtdr_pkg::M_IDLE;
			end
			default: begin
				state_d = wtdr_pkg::M_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wtdr_pkg::M_IDLE: begin
				if (req.start) begin
					ron_q  <= req.ron;
					r_q    <= req.roff;
					diff_q <= $signed({1'b0, req.roff}) - $signed({1'b0, req.ron});
					a_q    <= req.amax;
					m_q    <= req.mag;
					dh_q   <= '0;
					ph_q   <= '0;
					nh_q   <= '0;
				end
			end
			wtdr_pkg::M_MUL1: begin
				dh_q <= den_sum >>> 1;
				dl_q <= {den_sum[0], dl_q[RW-1:1]};
				ph_q <= p_sum[RW:1];
				pl_q <= {p_sum[0], pl_q[RW-1:1]};
				r_q  <= r_q >> 1;
				m_q  <= m_q >> 1;
				// A is rotated so that it is whole again for the second product.
				a_q  <= {a_q[0], a_q[RW-1:1]};
			end
			wtdr_pkg::M_MUL2: begin
				nh_q <= n_sum[2*RW:1];
				nl_q <= {n_sum[0], nl_q[RW-1:1]};
				a_q  <= {a_q[0], a_q[RW-1:1]};
				if (step_last) begin
					rem_q <= '0;
					q_q   <= '0;
					sat_q <= !den_pos;
				end
			end
			wtdr_pkg::M_DIV: begin
				rem_q          <= q_bit ? rem_sub[2*RW-1:0] : rem_shift[2*RW-1:0];
				{nh_q, nl_q}   <= {nh_q[2*RW-2:0], nl_q, 1'b0};
				q_q            <= {q_q[RW-2:0], q_bit};
				// Once the quotient passes the field width it stays saturated.
				sat_q          <= sat_q | q_q[RW-1];
			end
			wtdr_pkg::M_DONE: begin
			end
			default: begin
			end
		endcase
	end

	a_div_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wtdr_pkg::M_DIV |-> den_pos)
		else $error("divide running with a non-positive denominator");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("done held for more than one cycle");

	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wtdr_pkg::M_MUL1 && step_last) |=> state_q == wtdr_pkg::M_MUL2)
		else $error("first product did not hand over to the second");

endmodule

FILE: rtl/weight_to_differential_resistance.sv
// From the edge that takes the input word, clear, load and unused codes go straight to the
// output load; a read of a zero weight or under a zero maximum reads the store first; a
// mapped read reads the store, forms the bit-serial products, runs the restoring divide unless
// the denominator is not positive, then hands back. The output load waits for a free output
// register. One word is in flight at a time; the next is taken the cycle after the output load.
// Reset clears the running maximum and control state and loads r_on = 1000, r_off = 100000.
module weight_to_differential_resistance (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  wtdr_pkg::in_word_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output wtdr_pkg::out_word_t                   out_data,
	input  logic                                  cfg_write,
	input  logic [wtdr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wtdr_pkg::CFG_W-1:0]            cfg_data
);

	localparam int RW = wtdr_pkg::RES_W;
	localparam int WW = wtdr_pkg::WEIGHT_W;
	localparam int AW = wtdr_pkg::ADDR_W;

	wtdr_pkg::top_state_t state_q, state_d;

	logic [RW-1:0]        ron_q;
	logic [RW-1:0]        roff_q;
	logic [WW-1:0]        max_q;
	logic [WW-1:0]        max_d;
	logic                 out_valid_q;
	wtdr_pkg::out_word_t  out_q;
	wtdr_pkg::out_word_t  res_q;
	logic                 rd_ok_q;
	logic                 neg_side_q;

	logic                 accept;
	logic                 in_range;
	logic [WW-1:0]        in_mag;
	logic [AW-1:0]        store_addr;
	logic                 store_we;
	logic [WW-1:0]        store_rdata;
	logic signed [WW-1:0] rd_weight;
	logic [WW-1:0]        rd_mag;
	logic                 out_free;
	logic                 out_load;

	wtdr_pkg::map_req_t   map_req;
	wtdr_pkg::map_rsp_t   map_rsp;

	assign accept     = in_valid && in_ready;
	assign in_range   = (int'(in_data.neuron_index) < wtdr_pkg::NEURONS) &&
		(int'(in_data.output_index) < wtdr_pkg::OUTPUTS);
	assign in_mag     = in_data.weight[WW-1] ? WW'(-in_data.weight) : in_data.weight;
	assign store_addr = AW'(in_data.neuron_index) * AW'(wtdr_pkg::OUTPUTS) +
		AW'(in_data.output_index);
	assign store_we   = accept && (in_data.operation == wtdr_pkg::OP_LOAD) && in_range;

	// A read outside the store answers as a zero weight.
	assign rd_weight = rd_ok_q ? $signed(store_rdata) : '0;
	assign rd_mag    = rd_weight[WW-1] ? WW'(-rd_weight) : rd_weight;

	assign out_free  = !out_valid_q || out_ready;

	wtdr_ram #(
		.WIDTH(WW),
		.DEPTH(wtdr_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.addr (store_addr),
		.wdata(in_data.weight),
		.rdata(store_rdata)
	);

	wtdr_map u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (map_req),
		.rsp   (map_rsp)
	);

	always_comb begin
		max_d = max_q;
		unique case (in_data.operation)
			wtdr_pkg::OP_CLEAR: begin
				max_d = '0;
			end
			wtdr_pkg::OP_LOAD: begin
				if (in_range && (in_mag > max_q)) begin
					max_d = in_mag;
				end
			end
			wtdr_pkg::OP_READ: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		map_req.start = 1'b0;
		map_req.ron   = ron_q;
		map_req.roff  = roff_q;
		map_req.amax  = max_q;
		map_req.mag   = rd_mag;
		out_load      = 1'b0;
		unique case (state_q)
			wtdr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (in_data.operation == wtdr_pkg::OP_READ) ?
						wtdr_pkg::ST_RDMEM : wtdr_pkg::ST_PUSH;
				end
			end
			wtdr_pkg::ST_RDMEM: begin
				if ((max_q != '0) && (rd_weight != '0)) begin
					map_req.start = 1'b1;
					state_d       = wtdr_pkg::ST_CALC;
				end else begin
					state_d = wtdr_pkg::ST_PUSH;
				end
			end
			wtdr_pkg::ST_CALC: begin
				if (map_rsp.done) begin
					state_d = wtdr_pkg::ST_PUSH;
				end
			end
			wtdr_pkg::ST_PUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = wtdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wtdr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wtdr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			max_q       <= '0;
			ron_q       <= wtdr_pkg::RON_RESET;
			roff_q      <= wtdr_pkg::ROFF_RESET;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				max_q <= max_d;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					wtdr_pkg::CFG_ON_RES:  ron_q  <= cfg_data;
					wtdr_pkg::CFG_OFF_RES: roff_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.positive_resistance <= '0;
			res_q.negative_resistance <= '0;
			res_q.peak_weight         <= max_d;
			res_q.status              <= 1'b0;
			rd_ok_q                   <= in_range;
		end
		if (state_q == wtdr_pkg::ST_RDMEM) begin
			// The column that is not mapped, and every column of a zero weight, reads r_off.
			res_q.positive_resistance <= roff_q;
			res_q.negative_resistance <= roff_q;
			res_q.status              <= (max_q == '0);
			neg_side_q                <= rd_weight[WW-1];
		end
		if ((state_q == wtdr_pkg::ST_CALC) && map_rsp.done) begin
			if (neg_side_q) begin
				res_q.negative_resistance <= map_rsp.res;
			end else begin
				res_q.positive_resistance <= map_rsp.res;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		map_rsp.done |-> state_q == wtdr_pkg::ST_CALC)
		else $error("mapping finished while no read was waiting for it");

	a_degenerate_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |->
			(out_data.positive_resistance == out_data.negative_resistance))
		else $error("zero maximum word carries unequal resistances");

	a_load_raises_max: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_data.operation == wtdr_pkg::OP_LOAD) && in_range) |=>
			(max_q >= $past(in_mag)))
		else $error("running maximum below a loaded magnitude");

	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		max_q <= wtdr_pkg::MAG_MAX)
		else $error("running maximum above the largest magnitude");

endmodule

FILE: tb/resistance_checker.sv
`timescale 1ns / 1ps

module resistance_checker
	import wtdr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_word_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_word_t            out_data,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   words_due
);

	logic signed [WEIGHT_W-1:0] weight_copy [STORE_DEPTH];
	logic [WEIGHT_W-1:0]        peak_mag;
	logic [RES_W-1:0]           r_on;
	logic [RES_W-1:0]           r_off;
	out_word_t                  due_words [$];
	int                         flagged = 0;

	task automatic report_mismatch(input string msg);
		flagged++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Resistance of the column that carries the sign of the weight, saturating when the
	// denominator is not positive or the quotient does not fit the field.
	function automatic logic [RES_W-1:0] column_ohms(input logic [RES_W-1:0] ron,
		input logic [RES_W-1:0] roff, input logic [RES_W-1:0] amax, input logic [RES_W-1:0] mag);
		longint      den;
		logic [79:0] num;
		logic [79:0] quo;
		if (mag == '0)
			return roff;
		den = longint'(ron) * longint'(amax) - longint'(ron) * longint'(mag)
			+ longint'(roff) * longint'(mag);
		if (den <= 0)
			return '1;
		num = 80'(ron) * 80'(roff) * 80'(amax);
		quo = num / 80'(den);
		if (quo > 80'(24'hFFFFFF))
			return '1;
		return quo[RES_W-1:0];
	endfunction

	task automatic map_word(input in_word_t w);
		out_word_t                  o;
		logic [ADDR_W-1:0]          slot;
		logic signed [WEIGHT_W-1:0] sw;
		logic [WEIGHT_W-1:0]        mag;
		o = '0;
		slot = {w.neuron_index, w.output_index};
		case (w.operation)
			OP_CLEAR: peak_mag = '0;
			OP_LOAD: begin
				weight_copy[slot] = w.weight;
				mag = w.weight[WEIGHT_W-1] ? WEIGHT_W'(-w.weight) : w.weight;
				if (mag > peak_mag)
					peak_mag = mag;
			end
			OP_READ: begin
				sw = weight_copy[slot];
				mag = sw[WEIGHT_W-1] ? WEIGHT_W'(-sw) : sw;
				o.positive_resistance = r_off;
				o.negative_resistance = r_off;
				if (peak_mag == '0)
					o.status = 1'b1;
				else if (sw > 0)
					o.positive_resistance = column_ohms(r_on, r_off, peak_mag, mag);
				else if (sw < 0)
					o.negative_resistance = column_ohms(r_on, r_off, peak_mag, mag);
			end
			default: ;
		endcase
		o.peak_weight = peak_mag;
		due_words.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t got;
		out_word_t want;
		if (!arst_n) begin
			peak_mag = '0;
			r_on = RON_RESET;
			r_off = ROFF_RESET;
			due_words.delete();
			words_due <= 0;
		end else begin
			// The oldest pending word is retired before a new one is predicted.
			if (out_valid && out_ready) begin
				got = out_data;
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing pending", got));
				end else begin
					want = due_words.pop_front();
					if (got.positive_resistance !== want.positive_resistance)
						report_mismatch($sformatf("positive_resistance %0d, expected %0d",
							got.positive_resistance, want.positive_resistance));
					if (got.negative_resistance !== want.negative_resistance)
						report_mismatch($sformatf("negative_resistance %0d, expected %0d",
							got.negative_resistance, want.negative_resistance));
					if (got.peak_weight !== want.peak_weight)
						report_mismatch($sformatf("peak_weight %0d, expected %0d",
							got.peak_weight, want.peak_weight));
					if (got.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							got.status, want.status));
				end
			end
			if (in_valid && in_ready)
				map_word(in_data);
			if (cfg_write) begin
				case (cfg_index)
					CFG_ON_RES:  r_on = cfg_data;
					CFG_OFF_RES: r_off = cfg_data;
					default: ;
				endcase
			end
			words_due <= due_words.size();
		end
		mismatch_count <= flagged;
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import wtdr_pkg::*;

	localparam logic [OP_W-1:0]            OP_UNUSED   = 2'd3;
	localparam int                         QUIET_LIMIT = 4000;
	localparam int                         HOLD_CYCLES = 400;
	localparam logic [RES_W-1:0]           RES_TOP     = '1;
	localparam logic signed [WEIGHT_W-1:0] W_MAX       = 24'sh7FFFFF;
	localparam logic signed [WEIGHT_W-1:0] W_MIN       = 24'sh800000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_word_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   mismatch_total;
	int                   words_due;

	in_word_t outbox [$];
	bit       written_map [STORE_DEPTH];
	int       written_list [$];
	bit       steady = 1'b0;
	int       squeeze_asks = 0;

	always #1 clk = ~clk;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	weight_to_differential_resistance DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	resistance_checker mapping_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_total),
		.words_due      (words_due)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_word(input logic [OP_W-1:0] op,
		input logic [NEURON_W-1:0] row, input logic [OUTPUT_W-1:0] col,
		input logic [WEIGHT_W-1:0] w);
		in_word_t word;
		int       slot;
		word.operation = op;
		word.neuron_index = row;
		word.output_index = col;
		word.weight = w;
		slot = int'({row, col});
		if (op == OP_LOAD && !written_map[slot]) begin
			written_map[slot] = 1'b1;
			written_list.push_back(slot);
		end
		outbox.push_back(word);
	endfunction

	function automatic logic [WEIGHT_W-1:0] random_weight();
		logic signed [7:0] narrow;
		narrow = 8'($urandom);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return W_MAX;
			2: return W_MIN;
			3: return WEIGHT_W'($urandom_range(0, 16)) - WEIGHT_W'(8);
			4: return WEIGHT_W'(narrow);
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic void random_word();
		int              r;
		int              slot;
		logic [OP_W-1:0] op;
		r = $urandom_range(0, 99);
		if (r < 4)
			op = OP_CLEAR;
		else if (r < 7)
			op = OP_UNUSED;
		else if (r < 50 || written_list.size() == 0)
			op = OP_LOAD;
		else
			op = OP_READ;
		slot = $urandom_range(0, STORE_DEPTH - 1);
		// Reads only touch loaded entries; some loads overwrite one.
		if (op == OP_READ || (op == OP_LOAD && written_list.size() != 0
			&& $urandom_range(0, 3) == 0))
			slot = written_list[$urandom_range(0, written_list.size() - 1)];
		queue_word(op, slot[ADDR_W-1:OUTPUT_W], slot[OUTPUT_W-1:0], random_weight());
	endfunction

	// After a clear the stored extremes exceed the new maximum, which pushes the
	// mapping into its saturating corners.
	function automatic void above_max_probe();
		queue_word(OP_LOAD, '0, '0, W_MAX);
		queue_word(OP_LOAD, '1, '1, W_MIN);
		queue_word(OP_CLEAR, '0, '0, '0);
		queue_word(OP_LOAD, 6'd4, 3'd5, 24'd1);
		queue_word(OP_READ, '0, '0, '0);
		queue_word(OP_READ, '1, '1, '0);
		queue_word(OP_READ, 6'd4, 3'd5, '0);
	endfunction

	task automatic settle();
		do @(posedge clk);
		while (outbox.size() != 0 || in_valid || words_due != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_resistances(input logic [RES_W-1:0] ron, input logic [RES_W-1:0] roff);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= CFG_ON_RES;
		cfg_data <= ron;
		@(posedge clk);
		cfg_index <= CFG_OFF_RES;
		cfg_data <= roff;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin : feed_side
		int gap_left;
		gap_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			// The slot is free when no word is offered or the offered one was just taken.
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (outbox.size() != 0) begin
					in_data <= outbox.pop_front();
					in_valid <= 1'b1;
					gap_left = steady ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	initial begin : drain_side
		int pick;
		int span;
		int served;
		served = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (served != squeeze_asks) begin
				out_ready <= 1'b0;
				span = HOLD_CYCLES;
				served++;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					out_ready <= 1'b1;
					span = $urandom_range(1, 24);
				end else if (pick < 92) begin
					out_ready <= 1'b0;
					span = $urandom_range(1, 4);
				end else if (pick < 97) begin
					out_ready <= 1'b1;
					span = $urandom_range(100, 300);
				end else begin
					out_ready <= 1'b0;
					span = $urandom_range(20, 80);
				end
			end
			repeat (span) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("weight_to_differential_resistance test failed");
		$finish;
	end

	initial begin : stimulus
		logic [RES_W-1:0] ron;
		logic [RES_W-1:0] roff;
		wait (arst_n);
		// Extremes, zero weight, unit weights and an unused code under the reset resistances.
		queue_word(OP_LOAD, '0, '0, W_MAX);
		queue_word(OP_LOAD, '1, '1, W_MIN);
		queue_word(OP_LOAD, 6'd1, 3'd2, '0);
		queue_word(OP_LOAD, 6'd2, 3'd3, 24'd1);
		queue_word(OP_LOAD, 6'd3, 3'd4, '1);
		queue_word(OP_READ, '0, '0, '0);
		queue_word(OP_READ, '1, '1, '0);
		queue_word(OP_READ, 6'd1, 3'd2, '0);
		queue_word(OP_READ, 6'd2, 3'd3, '0);
		queue_word(OP_READ, 6'd3, 3'd4, '0);
		queue_word(OP_UNUSED, '1, '1, '1);
		// A read right after a clear sees a zero maximum.
		queue_word(OP_CLEAR, '1, '1, '1);
		queue_word(OP_READ, '0, '0, '0);

		set_resistances(24'd1, RES_TOP);
		squeeze_asks = 1;
		repeat (250) random_word();

		set_resistances(RES_TOP, RES_TOP - 24'd1);
		above_max_probe();
		repeat (250) random_word();

		set_resistances(RES_TOP, 24'd1);
		above_max_probe();
		repeat (250) random_word();

		set_resistances(RES_TOP, RES_TOP);
		steady = 1'b1;
		repeat (250) random_word();

		set_resistances(24'd1, 24'd1);
		steady = 1'b0;
		squeeze_asks = 2;
		repeat (250) random_word();

		for (int k = 0; k < 3; k++) begin
			ron = RES_W'($urandom_range(1, 65535));
			roff = (k == 2) ? RES_W'($urandom_range(1, RES_TOP))
				: RES_W'($urandom_range(ron, RES_TOP));
			set_resistances(ron, roff);
			repeat (200) random_word();
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_total == 0)
			$display("weight_to_differential_resistance test passed");
		else
			$display("weight_to_differential_resistance test failed");
		$finish;
	end

endmodule
